// ===== hdl/uvl_pkg.sv =====
package uvl_pkg;

   localparam int SQRT_CELLS   = 31;
   localparam int CORDIC_CELLS = 28;
   localparam int STAGES       = SQRT_CELLS + CORDIC_CELLS + 4;
   localparam int SQRT_FIRST   = 2;
   localparam int PREP_STAGE   = SQRT_FIRST + SQRT_CELLS;
   localparam int CORDIC_FIRST = PREP_STAGE + 1;
   localparam int LAST_STAGE   = STAGES - 1;

   localparam int COORD_W = 32;
   localparam int SQRT_W  = 62;
   localparam int VEC_W   = 44;
   localparam int ANG_W   = 34;
   localparam int DEG_W   = 25;
   localparam int LAT_W   = 24;
   localparam int THR_W   = 23;
   localparam int LVL_W   = 5;

   localparam logic [THR_W-1:0] THR_RESET = 23'd5898234;
   localparam logic [LAT_W-1:0] LAT_LIMIT = 24'd5898240;
   localparam logic [LAT_W-1:0] LON_LIMIT = 24'd11796480;

   localparam logic signed [ANG_W-1:0] ATAN_TURNS [CORDIC_CELLS] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
      34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
      34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
      34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
      34'sd652, 34'sd326, 34'sd163, 34'sd81,
      34'sd41, 34'sd20, 34'sd10, 34'sd5
   };

   typedef struct packed {
      logic [SQRT_W-1:0]         rem;
      logic [SQRT_W-1:0]         root;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } sqrt_word_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] px;
      logic signed [VEC_W-1:0] py;
      logic signed [ANG_W-1:0] ang;
      logic                    zero;
   } vec_word_type;

   typedef struct packed {
      logic signed [LAT_W-1:0] latitude;
      logic signed [DEG_W-1:0] longitude;
      logic                    at_pole;
   } out_word_type;

endpackage

// ===== hdl/uvl_sqrt_cell.sv =====
module uvl_sqrt_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [uvl_pkg::LVL_W-1:0] level,
   input  uvl_pkg::sqrt_word_type    d_in,
   output uvl_pkg::sqrt_word_type    d_out
);

   uvl_pkg::sqrt_word_type word_ff, word_in;
   logic [uvl_pkg::SQRT_W-1:0] bitv;
   logic [uvl_pkg::SQRT_W-1:0] trial;

   always_comb begin
      bitv    = uvl_pkg::SQRT_W'(1) << {level, 1'b0};
      trial   = d_in.root + bitv;
      word_in = d_in;
      if (d_in.rem >= trial) begin
         word_in.rem  = d_in.rem - trial;
         word_in.root = (d_in.root >> 1) + bitv;
      end else begin
         word_in.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign d_out = word_ff;

endmodule

// ===== hdl/uvl_cordic_cell.sv =====
module uvl_cordic_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [uvl_pkg::LVL_W-1:0] level,
   input  uvl_pkg::vec_word_type     d_in,
   output uvl_pkg::vec_word_type     d_out
);

   uvl_pkg::vec_word_type word_ff, word_in;
   logic signed [uvl_pkg::VEC_W-1:0] dx;
   logic signed [uvl_pkg::VEC_W-1:0] dy;

   always_comb begin
      dx      = d_in.py >>> level;
      dy      = d_in.px >>> level;
      word_in = d_in;
      if (d_in.py >= 0) begin
         word_in.px  = d_in.px + dx;
         word_in.py  = d_in.py - dy;
         word_in.ang = d_in.ang + uvl_pkg::ATAN_TURNS[level];
      end else begin
         word_in.px  = d_in.px - dx;
         word_in.py  = d_in.py + dy;
         word_in.ang = d_in.ang - uvl_pkg::ATAN_TURNS[level];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign d_out = word_ff;

endmodule

// ===== hdl/uvl_deg_conv.sv =====
module uvl_deg_conv (
   input  logic signed [uvl_pkg::ANG_W-1:0] ang,
   input  logic                             zero,
   input  logic [uvl_pkg::LAT_W-1:0]        limit,
   output logic signed [uvl_pkg::DEG_W-1:0] deg
);

   localparam int PROD_W = uvl_pkg::ANG_W + 10;
   localparam int FULL_W = PROD_W - 16;

   logic signed [PROD_W-1:0] a;
   logic signed [PROD_W-1:0] prod;
   logic signed [FULL_W-1:0] full;
   logic signed [FULL_W-1:0] lim;

   always_comb begin
      a    = zero ? '0 : PROD_W'(ang);
      prod = (a <<< 8) + (a <<< 6) + (a <<< 5) + (a <<< 3) + PROD_W'(32768);
      full = FULL_W'(prod >>> 16);
      lim  = FULL_W'({1'b0, limit});
      if (full > lim) begin
         deg = uvl_pkg::DEG_W'(lim);
      end else if (full < -lim) begin
         deg = uvl_pkg::DEG_W'(-lim);
      end else begin
         deg = uvl_pkg::DEG_W'(full);
      end
   end

endmodule

// ===== hdl/unit_vector_to_latlon.sv =====
// Channel   Direction  Word
// req_      in         coord_x, coord_y, coord_z (signed Q1.30)
// rsp_      out        latitude, longitude, at_pole
// csr_      in         pole_threshold
// One word enters per cycle while the skid register is empty; each result leaves in input order.
// The pipeline holds a 31-cell square root chain followed by two 28-cell CORDIC chains in parallel.
// Reset clears all valid bits and loads the pole threshold with its default.
// A stalled result parks in a skid register; the pipeline freezes only while it is full.

module unit_vector_to_latlon (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [uvl_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [uvl_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [uvl_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [uvl_pkg::LAT_W-1:0]    rsp_latitude,
   output logic signed [uvl_pkg::DEG_W-1:0]    rsp_longitude,
   output logic                                rsp_at_pole,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uvl_pkg::THR_W-1:0]           csr_pole_threshold
);

   localparam int CW = uvl_pkg::COORD_W;

   logic                           en;
   logic [uvl_pkg::STAGES-1:0]     valid_ff;
   logic [uvl_pkg::THR_W-1:0]      thr_ff;
   logic                           skid_valid_ff;
   uvl_pkg::out_word_type          skid_ff;
   uvl_pkg::out_word_type          out_ff, out_in;

   logic signed [CW-1:0]           x0_ff, y0_ff, z0_ff, z0_in;
   logic [CW-2:0]                  za_ff, za_in;
   uvl_pkg::sqrt_word_type         sq_start_ff;
   uvl_pkg::sqrt_word_type         sq [uvl_pkg::SQRT_CELLS+1];
   uvl_pkg::vec_word_type          lat_v [uvl_pkg::CORDIC_CELLS+1];
   uvl_pkg::vec_word_type          lon_v [uvl_pkg::CORDIC_CELLS+1];
   uvl_pkg::vec_word_type          lat_start_ff, lon_start_ff;

   logic signed [uvl_pkg::DEG_W-1:0] lat_deg, lon_deg;
   logic [uvl_pkg::LAT_W-1:0]        lat_abs;

   function automatic uvl_pkg::vec_word_type vec_start(input logic signed [CW-1:0] s,
                                                       input logic signed [CW-1:0] c);
      uvl_pkg::vec_word_type  v;
      logic signed [CW:0]     se;
      logic signed [CW:0]     ce;
      se     = (CW+1)'(s);
      ce     = (CW+1)'(c);
      v.zero = (s == 0) && (c == 0);
      if (c < 0) begin
         v.px  = uvl_pkg::VEC_W'(-ce) <<< 8;
         v.py  = uvl_pkg::VEC_W'(-se) <<< 8;
         v.ang = (s >= 0) ? (uvl_pkg::ANG_W'(1) <<< 31) : -(uvl_pkg::ANG_W'(1) <<< 31);
      end else begin
         v.px  = uvl_pkg::VEC_W'(ce) <<< 8;
         v.py  = uvl_pkg::VEC_W'(se) <<< 8;
         v.ang = '0;
      end
      return v;
   endfunction

   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         skid_valid_ff <= 1'b0;
         thr_ff        <= uvl_pkg::THR_RESET;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[uvl_pkg::STAGES-2:0], req_valid};
         end
         if (skid_valid_ff && rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end else if (en && valid_ff[uvl_pkg::LAST_STAGE] && !rsp_ready) begin
            skid_valid_ff <= 1'b1;
         end
         if (csr_valid) begin
            thr_ff <= csr_pole_threshold;
         end
      end
   end

   always_comb begin
      z0_in = req_coord_z;
      if (req_coord_z > (CW'(1) <<< 30)) begin
         z0_in = CW'(1) <<< 30;
      end else if (req_coord_z < -(CW'(1) <<< 30)) begin
         z0_in = -(CW'(1) <<< 30);
      end
      za_in = (z0_in < 0) ? (CW-1)'(-z0_in) : (CW-1)'(z0_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff              <= req_coord_x;
         y0_ff              <= req_coord_y;
         z0_ff              <= z0_in;
         za_ff              <= za_in;
         sq_start_ff.rem    <= (uvl_pkg::SQRT_W'(1) << 60)
                               - (uvl_pkg::SQRT_W'(za_ff) * uvl_pkg::SQRT_W'(za_ff));
         sq_start_ff.root   <= '0;
         sq_start_ff.x      <= x0_ff;
         sq_start_ff.y      <= y0_ff;
         sq_start_ff.z      <= z0_ff;
         lat_start_ff       <= vec_start(sq[uvl_pkg::SQRT_CELLS].z,
                                         CW'(sq[uvl_pkg::SQRT_CELLS].root[CW-2:0]));
         lon_start_ff       <= vec_start(sq[uvl_pkg::SQRT_CELLS].x,
                                         sq[uvl_pkg::SQRT_CELLS].y);
         out_ff             <= out_in;
      end
      if (en && valid_ff[uvl_pkg::LAST_STAGE] && !rsp_ready) begin
         skid_ff <= out_ff;
      end
   end

   assign sq[0] = sq_start_ff;

   for (genvar j = 0; j < uvl_pkg::SQRT_CELLS; j++) begin : g_sqrt
      uvl_sqrt_cell u_cell (
         .clock  (clock),
         .enable (en),
         .level  (uvl_pkg::LVL_W'(uvl_pkg::SQRT_CELLS - 1 - j)),
         .d_in   (sq[j]),
         .d_out  (sq[j+1])
      );
   end

   assign lat_v[0] = lat_start_ff;
   assign lon_v[0] = lon_start_ff;

   for (genvar j = 0; j < uvl_pkg::CORDIC_CELLS; j++) begin : g_cordic
      uvl_cordic_cell u_lat (
         .clock  (clock),
         .enable (en),
         .level  (uvl_pkg::LVL_W'(j)),
         .d_in   (lat_v[j]),
         .d_out  (lat_v[j+1])
      );
      uvl_cordic_cell u_lon (
         .clock  (clock),
         .enable (en),
         .level  (uvl_pkg::LVL_W'(j)),
         .d_in   (lon_v[j]),
         .d_out  (lon_v[j+1])
      );
   end

   uvl_deg_conv u_lat_conv (
      .ang   (lat_v[uvl_pkg::CORDIC_CELLS].ang),
      .zero  (lat_v[uvl_pkg::CORDIC_CELLS].zero),
      .limit (uvl_pkg::LAT_LIMIT),
      .deg   (lat_deg)
   );

   uvl_deg_conv u_lon_conv (
      .ang   (lon_v[uvl_pkg::CORDIC_CELLS].ang),
      .zero  (lon_v[uvl_pkg::CORDIC_CELLS].zero),
      .limit (uvl_pkg::LON_LIMIT),
      .deg   (lon_deg)
   );

   always_comb begin
      out_in.latitude  = uvl_pkg::LAT_W'(lat_deg);
      lat_abs          = (lat_deg < 0) ? uvl_pkg::LAT_W'(-lat_deg) : uvl_pkg::LAT_W'(lat_deg);
      out_in.at_pole   = lat_abs >= uvl_pkg::LAT_W'(thr_ff);
      out_in.longitude = out_in.at_pole ? '0 : lon_deg;
   end

   assign rsp_valid     = skid_valid_ff || valid_ff[uvl_pkg::LAST_STAGE];
   assign rsp_latitude  = skid_valid_ff ? skid_ff.latitude  : out_ff.latitude;
   assign rsp_longitude = skid_valid_ff ? skid_ff.longitude : out_ff.longitude;
   assign rsp_at_pole   = skid_valid_ff ? skid_ff.at_pole   : out_ff.at_pole;

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      valid_ff[uvl_pkg::LAST_STAGE] && !skid_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("stalled result not parked in the skid register");

   a_freeze : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while frozen");

   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ready |=> !skid_valid_ff)
      else $error("skid register not drained");

   a_pole_lon : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_pole |-> rsp_longitude == 0)
      else $error("longitude not zero at a pole");

endmodule
